>>> hdl/pidt_pkg.sv
// pidt_pkg: types and constants for the trapezoidal pid controller core
// shared by the core and its port checker; no dependencies

package pidt_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int ERR_W    = 17;
   localparam int DIFF_W   = 18;
   localparam int DERIV_W  = 35;
   localparam int INC_W    = 34;
   localparam int INTEG_W  = 40;
   localparam int MULA_W   = 17;
   localparam int MULB_W   = 25;
   localparam int PROD_W   = MULA_W + MULB_W;
   localparam int ACC_W    = 72;
   localparam int DRIVE_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = 16'sh8000;
   localparam logic [SAMPLE_W-1:0]        STEP_RESET  = 16'hFFFF;
   localparam logic [SAMPLE_W-1:0]        RATE_RESET  = 16'h0001;

   typedef enum logic [2:0] {
      REG_KP          = 3'd0,
      REG_KI          = 3'd1,
      REG_KD          = 3'd2,
      REG_STEP_TIME   = 3'd3,
      REG_SAMPLE_RATE = 3'd4,
      REG_UPPER       = 3'd5,
      REG_LOWER       = 3'd6,
      REG_LIMITS_EN   = 3'd7
   } reg_index_type;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_ERR  = 11'b000_0000_0010,
      ST_MD   = 11'b000_0000_0100,
      ST_MI   = 11'b000_0000_1000,
      ST_INTG = 11'b000_0001_0000,
      ST_K1   = 11'b000_0010_0000,
      ST_K2   = 11'b000_0100_0000,
      ST_K3   = 11'b000_1000_0000,
      ST_K4   = 11'b001_0000_0000,
      ST_K5   = 11'b010_0000_0000,
      ST_DONE = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      SH_NONE = 2'd0,
      SH_0    = 2'd1,
      SH_16   = 2'd2,
      SH_32   = 2'd3
   } shift_type;

endpackage

>>> hdl/pid_controller_trapezoidal_core.sv
// pid_controller_trapezoidal_core: fixed point pid controller, trapezoidal integral
// one shared 17x25 signed multiplier under a one-hot sequencer; uses pidt_pkg
//
//  channel   dir   handshake                   payload
//  req_      in    tvalid/tready               tdata: target, measurement
//  rsp_      out   tvalid/tready               tdata: drive; tuser: integral_clamped
//  csr_      in    psel/penable/pwrite/pready  8 registers at byte address 4*i
//
// an item steps from accept through err, md, mi, intg, k1-k5 and done: the multiplier issues
// seven products (derivative, trapezoid, kp, kd in two halves, ki in two halves)
// and the accumulator adds each of the five gain products once it sits in the product register.
// reset (synchronous, active high) clears the state and result word and sets the registers to their reset values.
// a result that is not taken holds the sequencer in its last step; req_tready is
// high only while the sequencer is idle.

module pid_controller_trapezoidal_core
   import pidt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [15:0] target, [31:16] measurement
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [31:0] drive
   output logic                rsp_tuser,   // [0] integral_clamped
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   // configuration
   logic signed [GAIN_W-1:0]   kp_ff, ki_ff, kd_ff;
   logic [SAMPLE_W-1:0]        step_ff, rate_ff;
   logic signed [SAMPLE_W-1:0] upper_ff, lower_ff;
   logic                       lim_ff;
   logic                       csr_wr;
   reg_index_type              csr_idx;

   // datapath
   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] target_ff, target_in, meas_ff, meas_in;
   logic signed [ERR_W-1:0]    err_ff, err_in, prev_ff, prev_in;
   logic signed [DIFF_W-1:0]   dif_ff, dif_in, tsum_ff, tsum_in;
   logic signed [DERIV_W-1:0]  deriv_ff, deriv_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic                       flag_ff, flag_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   shift_type                  sh_ff, sh_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]         rsp_drive_ff, rsp_drive_in;
   logic                       rsp_flag_ff, rsp_flag_in;

   logic signed [MULA_W-1:0]   mul_a;
   logic signed [MULB_W-1:0]   mul_b;
   logic signed [SAMPLE_W-1:0] sp;
   logic signed [ERR_W-1:0]    err_c;
   logic signed [INC_W-1:0]    inc;
   logic signed [INTEG_W:0]    sum_wide;
   logic signed [INTEG_W-1:0]  sum_sat, upper_q, lower_q;
   logic signed [ACC_W-1:0]    prod_ext, acc_add;
   logic [DRIVE_W-1:0]         drive_sat;
   logic                       req_acc, load_rsp, sat_hit;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      unique case (csr_idx)
         REG_KP:          csr_prdata = {{(CSR_DW-GAIN_W){kp_ff[GAIN_W-1]}}, kp_ff};
         REG_KI:          csr_prdata = {{(CSR_DW-GAIN_W){ki_ff[GAIN_W-1]}}, ki_ff};
         REG_KD:          csr_prdata = {{(CSR_DW-GAIN_W){kd_ff[GAIN_W-1]}}, kd_ff};
         REG_STEP_TIME:   csr_prdata = {{(CSR_DW-SAMPLE_W){1'b0}}, step_ff};
         REG_SAMPLE_RATE: csr_prdata = {{(CSR_DW-SAMPLE_W){1'b0}}, rate_ff};
         REG_UPPER:       csr_prdata = {{(CSR_DW-SAMPLE_W){upper_ff[SAMPLE_W-1]}}, upper_ff};
         REG_LOWER:       csr_prdata = {{(CSR_DW-SAMPLE_W){lower_ff[SAMPLE_W-1]}}, lower_ff};
         REG_LIMITS_EN:   csr_prdata = {{(CSR_DW-1){1'b0}}, lim_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= '0;
         ki_ff    <= '0;
         kd_ff    <= '0;
         step_ff  <= STEP_RESET;
         rate_ff  <= RATE_RESET;
         upper_ff <= UPPER_RESET;
         lower_ff <= LOWER_RESET;
         lim_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_KP:          kp_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_KI:          ki_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_KD:          kd_ff    <= csr_pwdata[GAIN_W-1:0];
            REG_STEP_TIME:   step_ff  <= csr_pwdata[SAMPLE_W-1:0];
            REG_SAMPLE_RATE: rate_ff  <= csr_pwdata[SAMPLE_W-1:0];
            REG_UPPER:       upper_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_LOWER:       lower_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_LIMITS_EN:   lim_ff   <= csr_pwdata[0];
            default:         lim_ff   <= lim_ff;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // setpoint clamp and error
   always_comb begin
      priority if (lim_ff && (target_ff < lower_ff)) sp = lower_ff;
      else if (lim_ff && (target_ff > upper_ff))     sp = upper_ff;
      else                                           sp = target_ff;
      err_c = ERR_W'(sp) - ERR_W'(meas_ff);
   end

   // integral update: floor half of the trapezoid, 40 bit saturation, limit clamp
   assign inc      = prod_ff[DERIV_W-1:1];
   assign sum_wide = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(inc);
   assign upper_q  = {{(INTEG_W-SAMPLE_W-FRAC_W){upper_ff[SAMPLE_W-1]}}, upper_ff, {FRAC_W{1'b0}}};
   assign lower_q  = {{(INTEG_W-SAMPLE_W-FRAC_W){lower_ff[SAMPLE_W-1]}}, lower_ff, {FRAC_W{1'b0}}};
   assign sat_hit  = sum_wide[INTEG_W] != sum_wide[INTEG_W-1];

   always_comb begin
      if (!sat_hit)                sum_sat = sum_wide[INTEG_W-1:0];
      else if (sum_wide[INTEG_W])  sum_sat = {1'b1, {(INTEG_W-1){1'b0}}};
      else                         sum_sat = {1'b0, {(INTEG_W-1){1'b1}}};
   end

   // shared multiplier and shifted accumulate
   assign prod_in  = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      unique case (sh_ff)
         SH_NONE: acc_add = '0;
         SH_0:    acc_add = prod_ext;
         SH_16:   acc_add = prod_ext <<< 16;
         SH_32:   acc_add = prod_ext <<< 32;
         default: acc_add = '0;
      endcase
   end

   // drive saturation to 32 bits after dropping the 8 extra fraction bits
   always_comb begin
      if ((&acc_ff[ACC_W-1:DRIVE_W+7]) || !(|acc_ff[ACC_W-1:DRIVE_W+7]))
         drive_sat = acc_ff[DRIVE_W+7:8];
      else if (acc_ff[ACC_W-1])
         drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
      else
         drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
   end

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      meas_in      = meas_ff;
      err_in       = err_ff;
      dif_in       = dif_ff;
      tsum_in      = tsum_ff;
      prev_in      = prev_ff;
      deriv_in     = deriv_ff;
      integ_in     = integ_ff;
      flag_in      = flag_ff;
      sh_in        = SH_NONE;
      acc_in       = acc_ff + acc_add;
      mul_a        = '0;
      mul_b        = '0;
      rsp_drive_in = rsp_drive_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               target_in = req_tdata[15:0];
               meas_in   = req_tdata[31:16];
               state_in  = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in   = err_c;
            dif_in   = DIFF_W'(err_c) - DIFF_W'(prev_ff);
            tsum_in  = DIFF_W'(err_c) + DIFF_W'(prev_ff);
            state_in = ST_MD;
         end
         ST_MD: begin
            mul_a    = {1'b0, rate_ff};
            mul_b    = MULB_W'(dif_ff);
            acc_in   = '0;
            state_in = ST_MI;
         end
         ST_MI: begin
            deriv_in = prod_ff[DERIV_W-1:0];
            mul_a    = {1'b0, step_ff};
            mul_b    = MULB_W'(tsum_ff);
            state_in = ST_INTG;
         end
         ST_INTG: begin
            flag_in = sat_hit;
            priority if (lim_ff && (sum_sat > upper_q)) begin
               integ_in = upper_q;
               flag_in  = 1'b1;
            end else if (lim_ff && (sum_sat < lower_q)) begin
               integ_in = lower_q;
               flag_in  = 1'b1;
            end else begin
               integ_in = sum_sat;
            end
            prev_in  = err_ff;
            mul_a    = MULA_W'(kp_ff);
            mul_b    = MULB_W'(err_ff);
            sh_in    = SH_16;
            state_in = ST_K1;
         end
         ST_K1: begin
            mul_a    = MULA_W'(kd_ff);
            mul_b    = MULB_W'(signed'(deriv_ff[DERIV_W-1:16]));
            sh_in    = SH_32;
            state_in = ST_K2;
         end
         ST_K2: begin
            mul_a    = MULA_W'(kd_ff);
            mul_b    = MULB_W'({1'b0, deriv_ff[15:0]});
            sh_in    = SH_16;
            state_in = ST_K3;
         end
         ST_K3: begin
            mul_a    = MULA_W'(ki_ff);
            mul_b    = MULB_W'(signed'(integ_ff[INTEG_W-1:16]));
            sh_in    = SH_16;
            state_in = ST_K4;
         end
         ST_K4: begin
            mul_a    = MULA_W'(ki_ff);
            mul_b    = MULB_W'({1'b0, integ_ff[15:0]});
            sh_in    = SH_0;
            state_in = ST_K5;
         end
         ST_K5: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_drive_in = drive_sat;
               rsp_flag_in  = flag_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         integ_ff     <= '0;
         sh_ff        <= SH_NONE;
         rsp_valid_ff <= 1'b0;
         rsp_drive_ff <= '0;
         rsp_flag_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         sh_ff        <= sh_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_drive_ff <= rsp_drive_in;
         rsp_flag_ff  <= rsp_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      meas_ff   <= meas_in;
      err_ff    <= err_in;
      dif_ff    <= dif_in;
      tsum_ff   <= tsum_in;
      deriv_ff  <= deriv_in;
      flag_ff   <= flag_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
   end

endmodule

>>> hdl/pidt_checker.sv
// pidt_checker: port-level assertions for the trapezoidal pid controller core
// bound to pid_controller_trapezoidal_core; uses pidt_pkg for port widths

module pidt_checker
   import pidt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [DRIVE_W-1:0]  rsp_tdata,
   input logic                rsp_tuser,
   input logic                csr_pready
);

   // out of reset the core is idle with no word pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("core not idle after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

   // one word in flight: input closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while busy");

   // no result can appear in the cycle after an input word is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result word too early");

   // register port never waits
   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind pid_controller_trapezoidal_core pidt_checker u_pidt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .csr_pready  (csr_pready)
);
